// File: src/msa_pkg.sv
// package for the measurement sequencer with safe abort
// states, commands, error codes, owner and capture flag positions, config defaults and structs
`timescale 1ns / 1ps

package msa_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgW  = 16;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [CfgW-1:0] RangeTimeoutRst  = 16'd500;
    localparam logic [CfgW-1:0] NeutralSettleRst = 16'd10;
    localparam logic [CfgW-1:0] SineSettleRst    = 16'd50;
    localparam logic [CfgW-1:0] OperateGuardRst  = 16'd20;
    localparam logic [CfgW-1:0] ReleaseGuardRst  = 16'd20;
    localparam logic [CfgW-1:0] CaptureTimeoutRst = 16'd100;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RANGE_TIMEOUT   = 3'd0,
        REG_NEUTRAL_SETTLE  = 3'd1,
        REG_SINE_SETTLE     = 3'd2,
        REG_OPERATE_GUARD   = 3'd3,
        REG_RELEASE_GUARD   = 3'd4,
        REG_CAPTURE_TIMEOUT = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_START = 2'd1,
        MODE_ACK = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CHK_OK = 2'd0,
        CHK_CLOCK = 2'd1,
        CHK_AMPL = 2'd2,
        CHK_INVALID = 2'd3
    } t_check;

    typedef enum logic [4:0] {
        S_IDLE = 5'd0, S_FORCE_SAFE = 5'd1, S_RANGE_REQ = 5'd2, S_RANGE_WAIT = 5'd3,
        S_NEUTRAL = 5'd4, S_NEUTRAL_WAIT = 5'd5, S_QUIET = 5'd6, S_PERMIT_ISSUE = 5'd7,
        S_PERMIT_VAL = 5'd8, S_AUX_PAUSE = 5'd9, S_RELAY_MEAS = 5'd10,
        S_OPER_GUARD = 5'd11, S_ADC_ACQ = 5'd12, S_SINE_START = 5'd13,
        S_SINE_SETTLE = 5'd14, S_DMA_START = 5'd15, S_DMA_WAIT = 5'd16,
        S_DMA_DONE = 5'd17, S_NEUTRAL_POST = 5'd18, S_NEUTRAL_PWAIT = 5'd19,
        S_RELAY_SAFE = 5'd20, S_REL_GUARD = 5'd21, S_EXC_OFF = 5'd22,
        S_RANGE_DIS = 5'd23, S_ADC_REL = 5'd24, S_ADC_RESTORE = 5'd25,
        S_AUX_RESUME = 5'd26, S_QUIET_EXIT = 5'd27, S_ANALYZE = 5'd28,
        S_DONE = 5'd29, S_ABORT = 5'd30, S_UNUSED = 5'd31
    } t_state;

    typedef enum logic [4:0] {
        C_NONE = 5'd0, C_RELAY_SAFE = 5'd1, C_RANGE_REQ = 5'd2, C_RANGE_STEP = 5'd3,
        C_EXC_NEUTRAL = 5'd4, C_QUIET_ON = 5'd5, C_PERMIT_ISSUE = 5'd6,
        C_PERMIT_VAL = 5'd7, C_AUX_PAUSE = 5'd8, C_RELAY_MEAS = 5'd9,
        C_ADC_ACQ = 5'd10, C_EXC_SINE = 5'd11, C_ADC_START = 5'd12,
        C_ADC_STOP = 5'd13, C_EXC_OFF = 5'd14, C_RANGE_DIS = 5'd15,
        C_ADC_RESTORE = 5'd16, C_AUX_RESUME = 5'd17, C_QUIET_OFF = 5'd18,
        C_ANALYZE = 5'd19, C_REJECT_SAFE = 5'd20
    } t_cmd;

    typedef enum logic [2:0] {
        L_NONE = 3'd0, L_RELAY = 3'd1, L_RANGE = 3'd2, L_EXC = 3'd3, L_ADC = 3'd4
    } t_latch;

    typedef enum logic [3:0] {
        E_OK = 4'd0, E_CLOCK = 4'd1, E_INVALID = 4'd2, E_AMPL = 4'd3, E_RANGE = 4'd4,
        E_PERMIT = 4'd5, E_RELAY = 4'd6, E_ADC = 4'd7, E_EXC = 4'd8, E_DMA = 4'd9,
        E_TIMEOUT = 4'd10, E_RESTORE = 4'd11, E_ABORT = 4'd12
    } t_err;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_BUSY = 3'd1, ST_ERROR = 3'd2, ST_INVALID = 3'd3, ST_NOTSUP = 3'd4
    } t_status;

    localparam int unsigned O_RELAY = 0, O_REACHED = 1, O_GUARD = 2, O_ADC = 3;
    localparam int unsigned O_AUX = 4, O_QUIET = 5, O_PERMIT = 6, O_RFAIL = 7;
    localparam int unsigned K_DONE = 0, K_DERR = 1, K_TOUT = 2, K_VALID = 3, K_DUMP = 4;

    typedef struct packed {
        logic [1:0]       mode;
        logic [TimeW-1:0] now_ms;
        logic [1:0]       start_check;
        logic             action_ok;
        logic             relay_in_measure;
        logic             safety_fault;
        logic             charger_present;
        logic             range_matches;
        logic             range_ready;
        logic             exc_dma_error;
        logic             adc_dma_err;
        logic             capture_done;
    } t_item;

    typedef struct packed {
        t_state  seq_state;
        logic [3:0] abort_step;
        t_err    first_error;
        logic [TimeW-1:0] deadline;
        logic [7:0] owner;
        logic [4:0] cap;
    } t_ctx;

    typedef struct packed {
        logic [4:0] seq_state_out;
        logic [4:0] command;
        logic [2:0] fault_latch;
        logic [3:0] error_code;
        logic [2:0] step_status;
        logic       relay_owned;
        logic       relay_measure_active;
        logic       dumpable;
    } t_result;

    typedef struct packed {
        logic [CfgW-1:0] range_timeout;
        logic [CfgW-1:0] neutral_settle;
        logic [CfgW-1:0] sine_settle;
        logic [CfgW-1:0] operate_guard;
        logic [CfgW-1:0] release_guard;
        logic [CfgW-1:0] capture_timeout;
    } t_cfg;

endpackage

// File: src/measurement_sequencer_safe_abort.sv
// top level of the measurement sequencer with safe abort
// input register, msa_step next-state logic, result register; uses msa_pkg
//
// channel  direction  handshake           payload
// in       input      i_valid / o_stall   mode, now_ms, checks and status flags
// out      output     o_valid / i_stall   state, command, latch, error, status, flags
// cfg      input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// one beat a cycle unless stalled; a beat is registered at the input register and its result at the result register
// while a result waits the input register still takes one beat, then o_stall rises
// once both registers are full o_stall follows i_stall in the same cycle
// the sequencer context updates at the result register, so each beat sees the last
// synchronous active-low reset clears context and valid flags and loads the config defaults
`timescale 1ns / 1ps

module measurement_sequencer_safe_abort import msa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_mode,
    input  logic [TimeW-1:0]    i_now_ms,
    input  logic [1:0]          i_start_check,
    input  logic                i_action_ok,
    input  logic                i_relay_in_measure,
    input  logic                i_safety_fault,
    input  logic                i_charger_present,
    input  logic                i_range_matches,
    input  logic                i_range_ready,
    input  logic                i_exc_dma_error,
    input  logic                i_adc_dma_err,
    input  logic                i_capture_done,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgW-1:0]     i_cfg_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [4:0]          o_seq_state_out,
    output logic [4:0]          o_command,
    output logic [2:0]          o_fault_latch,
    output logic [3:0]          o_error_code,
    output logic [2:0]          o_step_status,
    output logic                o_relay_owned,
    output logic                o_relay_measure_active,
    output logic                o_dumpable
);

    t_cfg    r_cfg;
    t_ctx    r_ctx;
    t_ctx    n_ctx;
    t_item   r_item;
    t_item   n_item;
    logic    r_in_v;
    t_result r_res;
    t_result n_res;
    logic    r_out_v;
    logic    adv;
    logic    in_take;

    assign adv     = r_in_v && (!r_out_v || !i_stall);
    assign o_stall = r_in_v && !adv;
    assign in_take = i_valid && !o_stall;

    always_comb begin
        n_item.mode             = i_mode;
        n_item.now_ms           = i_now_ms;
        n_item.start_check      = i_start_check;
        n_item.action_ok        = i_action_ok;
        n_item.relay_in_measure = i_relay_in_measure;
        n_item.safety_fault     = i_safety_fault;
        n_item.charger_present  = i_charger_present;
        n_item.range_matches    = i_range_matches;
        n_item.range_ready      = i_range_ready;
        n_item.exc_dma_error    = i_exc_dma_error;
        n_item.adc_dma_err      = i_adc_dma_err;
        n_item.capture_done     = i_capture_done;
    end

    msa_step u_step (
        .i_item (r_item),
        .i_ctx  (r_ctx),
        .i_cfg  (r_cfg),
        .o_ctx  (n_ctx),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_timeout   <= RangeTimeoutRst;
            r_cfg.neutral_settle  <= NeutralSettleRst;
            r_cfg.sine_settle     <= SineSettleRst;
            r_cfg.operate_guard   <= OperateGuardRst;
            r_cfg.release_guard   <= ReleaseGuardRst;
            r_cfg.capture_timeout <= CaptureTimeoutRst;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_RANGE_TIMEOUT:   r_cfg.range_timeout   <= i_cfg_data;
                REG_NEUTRAL_SETTLE:  r_cfg.neutral_settle  <= i_cfg_data;
                REG_SINE_SETTLE:     r_cfg.sine_settle     <= i_cfg_data;
                REG_OPERATE_GUARD:   r_cfg.operate_guard   <= i_cfg_data;
                REG_RELEASE_GUARD:   r_cfg.release_guard   <= i_cfg_data;
                REG_CAPTURE_TIMEOUT: r_cfg.capture_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx   <= '0;
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_take) r_in_v <= 1'b1;
            else if (adv) r_in_v <= 1'b0;
            if (adv) begin
                r_ctx   <= n_ctx;
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_item <= n_item;
        if (adv) r_res <= n_res;
    end

    assign o_valid                = r_out_v;
    assign o_seq_state_out        = r_res.seq_state_out;
    assign o_command              = r_res.command;
    assign o_fault_latch          = r_res.fault_latch;
    assign o_error_code           = r_res.error_code;
    assign o_step_status          = r_res.step_status;
    assign o_relay_owned          = r_res.relay_owned;
    assign o_relay_measure_active = r_res.relay_measure_active;
    assign o_dumpable             = r_res.dumpable;

    a_abort_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctx.seq_state != S_ABORT) |-> (r_ctx.abort_step == 4'd0 ||
            r_ctx.seq_state == S_IDLE || r_ctx.seq_state == S_DONE ||
            r_ctx.abort_step == 4'd1))
        else $error("abort step left over outside abort");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_v)
        else $error("result lost");

    a_dump_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && o_dumpable) |-> (o_seq_state_out == S_DONE ||
            o_seq_state_out == S_IDLE))
        else $error("dumpable while active");

endmodule

// File: src/msa_step.sv
// next-state logic of the sequencer for one beat
// depends on msa_pkg
`timescale 1ns / 1ps

module msa_step import msa_pkg::*; (
    input  t_item   i_item,
    input  t_ctx    i_ctx,
    input  t_cfg    i_cfg,
    output t_ctx    o_ctx,
    output t_result o_res
);

    t_ctx       c;
    t_cmd       cmd;
    t_latch     lat;
    t_status    st;
    logic       ok;
    logic       meas;
    logic       reached;
    logic [TimeW-1:0] diff;
    logic       act;

    assign diff    = i_item.now_ms - i_ctx.deadline;
    assign reached = ~diff[TimeW-1];

    function automatic t_ctx f_abort(input t_ctx x, input t_err e);
        t_ctx y;
        y = x;
        if (y.first_error == E_OK) y.first_error = e;
        y.seq_state = S_ABORT;
        y.cap[K_DUMP] = 1'b0;
        y.cap[K_VALID] = 1'b0;
        y.owner[O_GUARD] = y.owner[O_REACHED];
        y.abort_step = 4'd1;
        return y;
    endfunction

    function automatic logic [TimeW-1:0] f_dl(input logic [TimeW-1:0] n,
                                             input logic [CfgW-1:0] d);
        return n + {{(TimeW-CfgW){1'b0}}, d};
    endfunction

    always_comb begin
        c    = i_ctx;
        cmd  = C_NONE;
        lat  = L_NONE;
        st   = ST_OK;
        ok   = i_item.action_ok;
        meas = i_item.relay_in_measure;
        case (t_mode'(i_item.mode))
            MODE_TICK: begin
                if (c.seq_state == S_IDLE || c.seq_state == S_DONE) begin
                    st = ST_OK;
                end else if (c.seq_state == S_ABORT) begin
                    st = ST_ERROR;
                    case (c.abort_step)
                        4'd1: begin
                            cmd = C_ADC_STOP;
                            c.abort_step = 4'd2;
                        end
                        4'd2: begin
                            cmd = C_EXC_OFF;
                            if (!ok) lat = L_EXC;
                            c.abort_step = 4'd3;
                        end
                        4'd3: begin
                            cmd = C_RELAY_SAFE;
                            if (!ok) lat = L_RELAY;
                            c.owner[O_RELAY] = c.owner[O_GUARD];
                            c.abort_step = 4'd4;
                        end
                        4'd4: begin
                            cmd = C_RANGE_DIS;
                            if (!ok) lat = L_RANGE;
                            if (c.owner[O_GUARD]) begin
                                c.deadline = f_dl(i_item.now_ms, i_cfg.release_guard);
                                c.abort_step = 4'd5;
                            end else begin
                                c.abort_step = 4'd6;
                            end
                        end
                        4'd5: begin
                            if (reached) begin
                                c.owner[O_RELAY] = 1'b0;
                                c.abort_step = 4'd6;
                            end
                        end
                        4'd6: begin
                            if (c.owner[O_ADC] || c.owner[O_AUX]) begin
                                cmd = C_ADC_RESTORE;
                                if (!ok) begin
                                    if (!c.owner[O_RFAIL]) begin
                                        c.owner[O_RFAIL] = 1'b1;
                                        lat = L_ADC;
                                    end
                                    if (c.first_error == E_OK) c.first_error = E_RESTORE;
                                end
                                c.owner[O_ADC] = 1'b0;
                                c.abort_step = (ok && c.owner[O_AUX]) ? 4'd7 : 4'd8;
                            end else begin
                                c.abort_step = 4'd8;
                            end
                        end
                        4'd7: begin
                            if (c.owner[O_AUX]) begin
                                cmd = C_AUX_RESUME;
                                c.owner[O_AUX] = 1'b0;
                            end
                            c.abort_step = 4'd8;
                        end
                        4'd8: begin
                            if (c.owner[O_QUIET]) begin
                                cmd = C_QUIET_OFF;
                                c.owner[O_QUIET] = 1'b0;
                            end
                            c.cap[K_DUMP] = 1'b0;
                            c.cap[K_VALID] = 1'b0;
                            c.seq_state = S_IDLE;
                            c.abort_step = 4'd0;
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    if (meas && (i_item.safety_fault || i_item.charger_present ||
                                 !i_item.range_matches || i_item.exc_dma_error ||
                                 i_item.adc_dma_err)) begin
                        c = f_abort(c, E_ABORT);
                    end else begin
                        case (c.seq_state)
                            S_FORCE_SAFE: begin
                                cmd = C_RELAY_SAFE;
                                if (!ok) begin
                                    lat = L_RELAY;
                                    c = f_abort(c, E_RELAY);
                                end else c.seq_state = S_RANGE_REQ;
                            end
                            S_RANGE_REQ: begin
                                cmd = C_RANGE_REQ;
                                if (!ok) c = f_abort(c, E_RANGE);
                                else begin
                                    c.deadline = f_dl(i_item.now_ms, i_cfg.range_timeout);
                                    c.seq_state = S_RANGE_WAIT;
                                end
                            end
                            S_RANGE_WAIT: begin
                                cmd = C_RANGE_STEP;
                                if (!ok) c = f_abort(c, E_RANGE);
                                else if (i_item.range_ready) c.seq_state = S_NEUTRAL;
                                else if (reached) c = f_abort(c, E_RANGE);
                            end
                            S_NEUTRAL: begin
                                cmd = C_EXC_NEUTRAL;
                                if (!ok) c = f_abort(c, E_EXC);
                                else begin
                                    c.deadline = f_dl(i_item.now_ms, i_cfg.neutral_settle);
                                    c.seq_state = S_NEUTRAL_WAIT;
                                end
                            end
                            S_NEUTRAL_WAIT: if (reached) c.seq_state = S_QUIET;
                            S_QUIET: begin
                                cmd = C_QUIET_ON;
                                c.owner[O_QUIET] = 1'b1;
                                c.seq_state = S_PERMIT_ISSUE;
                            end
                            S_PERMIT_ISSUE: begin
                                cmd = C_PERMIT_ISSUE;
                                if (!ok) c = f_abort(c, E_PERMIT);
                                else c.seq_state = S_PERMIT_VAL;
                            end
                            S_PERMIT_VAL: begin
                                cmd = C_PERMIT_VAL;
                                if (!ok) c = f_abort(c, E_PERMIT);
                                else begin
                                    c.owner[O_PERMIT] = 1'b1;
                                    c.seq_state = S_AUX_PAUSE;
                                end
                            end
                            S_AUX_PAUSE: begin
                                cmd = C_AUX_PAUSE;
                                c.owner[O_AUX] = 1'b1;
                                c.seq_state = S_RELAY_MEAS;
                            end
                            S_RELAY_MEAS: begin
                                if (!c.owner[O_PERMIT]) c = f_abort(c, E_PERMIT);
                                else begin
                                    cmd = C_RELAY_MEAS;
                                    if (!ok || !meas) begin
                                        lat = L_RELAY;
                                        c = f_abort(c, E_RELAY);
                                    end else begin
                                        c.owner[O_RELAY] = 1'b1;
                                        c.owner[O_REACHED] = 1'b1;
                                        c.deadline = f_dl(i_item.now_ms, i_cfg.operate_guard);
                                        c.seq_state = S_OPER_GUARD;
                                    end
                                end
                            end
                            S_OPER_GUARD: if (reached) c.seq_state = S_ADC_ACQ;
                            S_ADC_ACQ: begin
                                cmd = C_ADC_ACQ;
                                c.owner[O_ADC] = 1'b1;
                                if (!ok) c = f_abort(c, E_ADC);
                                else c.seq_state = S_SINE_START;
                            end
                            S_SINE_START: begin
                                cmd = C_EXC_SINE;
                                if (!ok) c = f_abort(c, E_EXC);
                                else begin
                                    c.deadline = f_dl(i_item.now_ms, i_cfg.sine_settle);
                                    c.seq_state = S_SINE_SETTLE;
                                end
                            end
                            S_SINE_SETTLE: begin
                                if (i_item.exc_dma_error) c = f_abort(c, E_EXC);
                                else if (reached) c.seq_state = S_DMA_START;
                            end
                            S_DMA_START: begin
                                cmd = C_ADC_START;
                                if (!ok) c = f_abort(c, E_ADC);
                                else begin
                                    c.deadline = f_dl(i_item.now_ms, i_cfg.capture_timeout);
                                    c.seq_state = S_DMA_WAIT;
                                end
                            end
                            S_DMA_WAIT: begin
                                if (i_item.adc_dma_err || i_item.exc_dma_error) begin
                                    c.cap[K_DERR] = 1'b1;
                                    c = f_abort(c, E_DMA);
                                end else if (i_item.capture_done) begin
                                    c.cap[K_DONE] = 1'b1;
                                    c.seq_state = S_DMA_DONE;
                                end else if (reached) begin
                                    c.cap[K_TOUT] = 1'b1;
                                    c = f_abort(c, E_TIMEOUT);
                                end
                            end
                            S_DMA_DONE: begin
                                cmd = C_ADC_STOP;
                                c.seq_state = S_NEUTRAL_POST;
                            end
                            S_NEUTRAL_POST: begin
                                cmd = C_EXC_NEUTRAL;
                                if (!ok) c = f_abort(c, E_EXC);
                                else begin
                                    c.deadline = f_dl(i_item.now_ms, i_cfg.neutral_settle);
                                    c.seq_state = S_NEUTRAL_PWAIT;
                                end
                            end
                            S_NEUTRAL_PWAIT: if (reached) c.seq_state = S_RELAY_SAFE;
                            S_RELAY_SAFE: begin
                                cmd = C_RELAY_SAFE;
                                if (!ok) begin
                                    lat = L_RELAY;
                                    c = f_abort(c, E_RELAY);
                                end else begin
                                    c.deadline = f_dl(i_item.now_ms, i_cfg.release_guard);
                                    c.seq_state = S_REL_GUARD;
                                end
                            end
                            S_REL_GUARD: begin
                                if (reached) begin
                                    c.owner[O_RELAY] = 1'b0;
                                    c.seq_state = S_EXC_OFF;
                                end
                            end
                            S_EXC_OFF: begin
                                cmd = C_EXC_OFF;
                                if (!ok) begin
                                    lat = L_EXC;
                                    c = f_abort(c, E_EXC);
                                end else c.seq_state = S_RANGE_DIS;
                            end
                            S_RANGE_DIS: begin
                                cmd = C_RANGE_DIS;
                                if (!ok) begin
                                    lat = L_RANGE;
                                    c = f_abort(c, E_RANGE);
                                end else c.seq_state = S_ADC_REL;
                            end
                            S_ADC_REL: begin
                                cmd = C_ADC_STOP;
                                c.seq_state = S_ADC_RESTORE;
                            end
                            S_ADC_RESTORE: begin
                                cmd = C_ADC_RESTORE;
                                if (!ok) begin
                                    if (!c.owner[O_RFAIL]) begin
                                        c.owner[O_RFAIL] = 1'b1;
                                        lat = L_ADC;
                                    end
                                    if (c.first_error == E_OK) c.first_error = E_RESTORE;
                                    c = f_abort(c, E_RESTORE);
                                end else begin
                                    c.owner[O_ADC] = 1'b0;
                                    c.seq_state = S_AUX_RESUME;
                                end
                            end
                            S_AUX_RESUME: begin
                                cmd = C_AUX_RESUME;
                                c.owner[O_AUX] = 1'b0;
                                c.seq_state = S_QUIET_EXIT;
                            end
                            S_QUIET_EXIT: begin
                                cmd = C_QUIET_OFF;
                                c.owner[O_QUIET] = 1'b0;
                                c.seq_state = S_ANALYZE;
                            end
                            S_ANALYZE: begin
                                cmd = C_ANALYZE;
                                if (c.cap[K_DONE] && !c.cap[K_DERR] && !c.cap[K_TOUT] &&
                                    !c.owner[O_RFAIL]) begin
                                    c.cap[K_VALID] = 1'b1;
                                    c.cap[K_DUMP] = 1'b1;
                                end else begin
                                    c.cap[K_VALID] = 1'b0;
                                    c.cap[K_DUMP] = 1'b0;
                                end
                                c.seq_state = S_DONE;
                            end
                            default: c = f_abort(c, E_INVALID);
                        endcase
                    end
                    if (c.seq_state == S_ABORT) st = ST_ERROR;
                    else if (c.seq_state == S_DONE) st = ST_OK;
                    else st = ST_BUSY;
                end
            end
            MODE_START: begin
                if (c.seq_state != S_IDLE && c.seq_state != S_DONE) begin
                    st = ST_BUSY;
                end else begin
                    c.cap[K_DUMP] = 1'b0;
                    c.cap[K_VALID] = 1'b0;
                    c.owner[O_RFAIL] = 1'b0;
                    c.owner[O_PERMIT] = 1'b0;
                    c.owner[O_RELAY] = 1'b0;
                    c.owner[O_REACHED] = 1'b0;
                    c.owner[O_GUARD] = 1'b0;
                    c.abort_step = 4'd0;
                    case (t_check'(i_item.start_check))
                        CHK_CLOCK: begin
                            c.first_error = E_CLOCK;
                            c.seq_state = S_IDLE;
                            cmd = C_REJECT_SAFE;
                            st = ST_ERROR;
                        end
                        CHK_AMPL: begin
                            c.first_error = E_AMPL;
                            cmd = C_REJECT_SAFE;
                            st = ST_NOTSUP;
                        end
                        CHK_INVALID: begin
                            c.first_error = E_INVALID;
                            st = ST_INVALID;
                        end
                        default: begin
                            c.first_error = E_OK;
                            c.cap = '0;
                            c.seq_state = S_FORCE_SAFE;
                            st = ST_BUSY;
                        end
                    endcase
                end
            end
            MODE_ACK: begin
                c.seq_state = S_IDLE;
                c.cap[K_DUMP] = 1'b0;
                c.owner[O_RELAY] = 1'b0;
                st = ST_OK;
            end
            default: st = ST_INVALID;
        endcase
    end

    assign act   = (c.seq_state != S_IDLE) && (c.seq_state != S_DONE);
    assign o_ctx = c;

    always_comb begin
        o_res.seq_state_out        = c.seq_state;
        o_res.command              = cmd;
        o_res.fault_latch          = lat;
        o_res.error_code           = c.first_error;
        o_res.step_status          = st;
        o_res.relay_owned          = act & c.owner[O_RELAY];
        o_res.relay_measure_active = act & meas;
        o_res.dumpable             = c.cap[K_DUMP] & c.cap[K_VALID];
    end

endmodule
